### design/word_frequency_counter_assert.svh
// Assertion macros for the word frequency counter.
// Used by the top level only; needs clk and rst in scope.
`ifndef WORD_FREQUENCY_COUNTER_ASSERT_SVH
`define WORD_FREQUENCY_COUNTER_ASSERT_SVH

// same-cycle implication
`define WFC_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("word_frequency_counter check failed");

// next-cycle implication
`define WFC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("word_frequency_counter next-cycle check failed");

`endif

### design/wfc_pkg.sv
// Shared types, constants and byte classification for the word frequency counter.
// No dependencies.
package wfc_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int WORD_BYTES_DEF  = 64;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_FEED  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic row_we;
    logic cnt_we;
  } tbl_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) r = b + 8'd32;
    return r;
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    logic d;
    unique case (b)
      8'h00, 8'h20, 8'h09, 8'h0D, 8'h0A, 8'h2E, 8'h2C, 8'h3A, 8'h3B,
      8'h21, 8'h3F, 8'h28, 8'h29, 8'h22, 8'h27, 8'h2D: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### design/wfc_word.sv
// Pending word buffer: collects folded bytes, tracks length and truncation.
// Depends on nothing but its parameter.
module wfc_word #(
  parameter int WORD_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [7:0]                  push_byte,
  input  logic                        clear,
  output logic [WORD_BYTES*8-1:0]     chars,
  output logic [$clog2(WORD_BYTES)-1:0] len,
  output logic                        trunc,
  output logic                        in_word
);
  localparam int CW = $clog2(WORD_BYTES);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      chars   <= '0;
      len     <= '0;
      trunc   <= 1'b0;
      in_word <= 1'b0;
    end else if (push) begin
      if (len < CW'(WORD_BYTES - 1)) begin
        chars[{len, 3'b000} +: 8] <= push_byte;
        len <= len + 1'b1;
      end else begin
        trunc <= 1'b1;
      end
      in_word <= 1'b1;
    end
  end
endmodule

### design/wfc_table.sv
// Word table: row memory {length, chars} and count memory, registered read.
// Depends on wfc_pkg for the control struct.
module wfc_table #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WORD_BYTES  = 64
) (
  input  logic                                        clk,
  input  wfc_pkg::tbl_ctl_t                           ctl,
  input  logic [$clog2(MAX_ENTRIES)-1:0]              rd_addr,
  input  logic [$clog2(MAX_ENTRIES)-1:0]              wr_addr,
  input  logic [WORD_BYTES*8+$clog2(WORD_BYTES)-1:0]  wr_row,
  input  logic [31:0]                                 wr_cnt,
  output logic [WORD_BYTES*8+$clog2(WORD_BYTES)-1:0]  rd_row,
  output logic [31:0]                                 rd_cnt
);
  localparam int RW = WORD_BYTES*8 + $clog2(WORD_BYTES);

  logic [RW-1:0] rows [MAX_ENTRIES];
  logic [31:0]   cnts [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.row_we) rows[wr_addr] <= wr_row;
    if (ctl.cnt_we) cnts[wr_addr] <= wr_cnt;
    if (ctl.rd_en) begin
      rd_row <= rows[rd_addr];
      rd_cnt <= cnts[rd_addr];
    end
  end
endmodule

### design/word_frequency_counter.sv
// channel | signals                                   | dir
// in      | in_valid, in_stall, command..char_position | in
// out     | out_valid, out_stall, result_kind..entry_valid | out
// A text byte inside a word is accepted without raising in_stall. A word end runs
// SCAN, which reads and compares the entries in index order until one matches or
// all are compared, then PUT; a read runs RDWAIT then PUT. Reset clears the entry
// count and pending word; table memories are not cleared. in_stall is high while a
// word or read is in progress and while a finished result waits for the output
// register to free up.
// Top level of the word frequency counter; uses wfc_pkg, wfc_word, wfc_table
// and the assertion macros header.
`include "word_frequency_counter_assert.svh"
module word_frequency_counter #(
  parameter int MAX_ENTRIES = wfc_pkg::MAX_ENTRIES_DEF,
  parameter int WORD_BYTES  = wfc_pkg::WORD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  text_byte,
  input  logic [9:0]  entry_index,
  input  logic [5:0]  char_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [9:0]  slot,
  output logic [31:0] occurrences,
  output logic        newly_added,
  output logic        was_truncated,
  output logic        table_full_drop,
  output logic [7:0]  char_out,
  output logic [5:0]  word_length,
  output logic        entry_valid
);
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int TW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = $clog2(WORD_BYTES);
  localparam int CB = WORD_BYTES * 8;
  localparam int RW = CB + CW;

  wfc_pkg::state_t state, state_next;
  wfc_pkg::tbl_ctl_t ctl;

  logic [TW-1:0] total, total_next;
  logic [TW-1:0] rd_idx, rd_idx_next;
  logic [EW-1:0] cmp_idx, cmp_idx_next;
  logic          cmp_vld, cmp_vld_next;
  logic [9:0]    rq_idx;
  logic [5:0]    rq_pos;
  logic          rq_ok;

  logic [EW-1:0] rd_addr, wr_addr;
  logic [RW-1:0] rd_row;
  logic [31:0]   rd_cnt, wr_cnt;

  logic          push, clear;
  logic [CB-1:0] w_chars;
  logic [CW-1:0] w_len;
  logic          w_trunc, w_inside;

  logic [7:0] folded;
  logic       delim, accept, start_scan, start_read, issue, hit, done, out_free;
  logic [CW-1:0] s_len;
  logic [CW-1:0] pos_w;

  logic        res_load;
  logic        res_kind, res_kind_q;
  logic [9:0]  res_slot, res_slot_q;
  logic [31:0] res_occ, res_occ_q;
  logic        res_new, res_new_q, res_trunc, res_trunc_q, res_drop, res_drop_q;
  logic [7:0]  res_char, res_char_q;
  logic [5:0]  res_len, res_len_q;
  logic        res_valid, res_valid_q;

  wfc_word #(.WORD_BYTES(WORD_BYTES)) u_word (
    .clk, .rst, .push, .push_byte(folded), .clear,
    .chars(w_chars), .len(w_len), .trunc(w_trunc), .in_word(w_inside)
  );

  wfc_table #(.MAX_ENTRIES(MAX_ENTRIES), .WORD_BYTES(WORD_BYTES)) u_table (
    .clk, .ctl, .rd_addr, .wr_addr, .wr_row({w_len, w_chars}), .wr_cnt,
    .rd_row, .rd_cnt
  );

  assign in_stall   = (state != wfc_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign folded     = wfc_pkg::fold(text_byte);
  assign delim      = wfc_pkg::is_delim(folded);
  assign start_scan = accept && w_inside &&
                      ((command == wfc_pkg::CMD_FEED && delim) ||
                       command == wfc_pkg::CMD_FLUSH);
  assign start_read = accept && command == wfc_pkg::CMD_READ;
  assign issue      = rd_idx < total;
  assign hit        = cmp_vld && (rd_row == {w_len, w_chars});
  assign done       = !hit && !issue && !cmp_vld;
  assign out_free   = !out_valid || !out_stall;
  assign s_len      = rd_row[RW-1:CB];
  assign pos_w      = CW'(rq_pos);

  always_comb begin
    unique case (state)
      wfc_pkg::ST_IDLE: begin
        if (start_scan) state_next = wfc_pkg::ST_SCAN;
        else if (start_read) state_next = wfc_pkg::ST_RDWAIT;
        else state_next = wfc_pkg::ST_IDLE;
      end
      wfc_pkg::ST_SCAN:   state_next = (hit || done) ? wfc_pkg::ST_PUT : wfc_pkg::ST_SCAN;
      wfc_pkg::ST_RDWAIT: state_next = wfc_pkg::ST_PUT;
      wfc_pkg::ST_PUT:    state_next = out_free ? wfc_pkg::ST_IDLE : wfc_pkg::ST_PUT;
      default:            state_next = wfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    rd_addr      = rd_idx[EW-1:0];
    wr_addr      = cmp_idx;
    wr_cnt       = 32'd1;
    push         = 1'b0;
    clear        = 1'b0;
    total_next   = total;
    rd_idx_next  = rd_idx;
    cmp_idx_next = cmp_idx;
    cmp_vld_next = 1'b0;
    res_load     = 1'b0;
    res_kind     = wfc_pkg::KIND_WORD;
    res_slot     = '0;
    res_occ      = '0;
    res_new      = 1'b0;
    res_trunc    = w_trunc;
    res_drop     = 1'b0;
    res_char     = '0;
    res_len      = 6'(w_len);
    res_valid    = 1'b0;
    unique case (state)
      wfc_pkg::ST_IDLE: begin
        rd_idx_next = '0;
        push = accept && command == wfc_pkg::CMD_FEED && !delim;
        if (start_read) begin
          ctl.rd_en = 1'b1;
          rd_addr   = EW'(entry_index);
        end
      end
      wfc_pkg::ST_SCAN: begin
        if (hit) begin
          ctl.cnt_we = 1'b1;
          wr_cnt     = (rd_cnt == wfc_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
          res_slot   = 10'(cmp_idx);
          res_occ    = wr_cnt;
          res_load   = 1'b1;
          clear      = 1'b1;
        end else if (issue) begin
          ctl.rd_en    = 1'b1;
          rd_idx_next  = rd_idx + 1'b1;
          cmp_vld_next = 1'b1;
          cmp_idx_next = rd_idx[EW-1:0];
        end else if (done) begin
          if (total != TW'(MAX_ENTRIES)) begin
            ctl.row_we = 1'b1;
            ctl.cnt_we = 1'b1;
            wr_addr    = total[EW-1:0];
            total_next = total + 1'b1;
            res_slot   = 10'(total);
            res_occ    = 32'd1;
            res_new    = 1'b1;
          end else begin
            res_drop = 1'b1;
          end
          res_load = 1'b1;
          clear    = 1'b1;
        end
      end
      wfc_pkg::ST_RDWAIT: begin
        res_kind  = wfc_pkg::KIND_READ;
        res_slot  = rq_idx;
        res_trunc = 1'b0;
        res_valid = rq_ok;
        res_load  = 1'b1;
        if (rq_ok) begin
          res_occ = rd_cnt;
          res_len = 6'(s_len);
          if (32'(rq_pos) < 32'(s_len)) res_char = rd_row[{pos_w, 3'b000} +: 8];
        end else begin
          res_len = '0;
        end
      end
      wfc_pkg::ST_PUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wfc_pkg::ST_IDLE;
      total     <= '0;
      rd_idx    <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      total   <= total_next;
      rd_idx  <= rd_idx_next;
      cmp_vld <= cmp_vld_next;
      if (state == wfc_pkg::ST_PUT && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    if (start_read) begin
      rq_idx <= entry_index;
      rq_pos <= char_position;
      rq_ok  <= 32'(entry_index) < 32'(total);
    end
    if (res_load) begin
      res_kind_q  <= res_kind;
      res_slot_q  <= res_slot;
      res_occ_q   <= res_occ;
      res_new_q   <= res_new;
      res_trunc_q <= res_trunc;
      res_drop_q  <= res_drop;
      res_char_q  <= res_char;
      res_len_q   <= res_len;
      res_valid_q <= res_valid;
    end
    if (state == wfc_pkg::ST_PUT && out_free) begin
      result_kind     <= res_kind_q;
      slot            <= res_slot_q;
      occurrences     <= res_occ_q;
      newly_added     <= res_new_q;
      was_truncated   <= res_trunc_q;
      table_full_drop <= res_drop_q;
      char_out        <= res_char_q;
      word_length     <= res_len_q;
      entry_valid     <= res_valid_q;
    end
  end

  `WFC_CHECK(a_total_bound, 1'b1, total <= TW'(MAX_ENTRIES))
  `WFC_CHECK(a_append_room, ctl.row_we, total < TW'(MAX_ENTRIES))
  `WFC_CHECK(a_cnt_in_scan, ctl.cnt_we, state == wfc_pkg::ST_SCAN)
  `WFC_CHECK_NEXT(a_append_grows, ctl.row_we, total == $past(total) + 1'b1)

endmodule
